### src/xmr_pkg.sv
// shared types and constants of the xmodem receiver
// no dependencies
package xmr_pkg;

  localparam int unsigned MaxPayload = 1024;
  localparam int unsigned ShortPayload = 128;
  localparam int unsigned PosW = $clog2(MaxPayload + 5);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_INV = 8'h43;

  localparam logic [16:0] TICK_MAX = 17'h1FFFF;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] VERD_NONE = 2'd0;
  localparam logic [1:0] VERD_COMMIT = 2'd1;
  localparam logic [1:0] VERD_DISCARD = 2'd2;

  localparam logic [2:0] EXIT_RUN = 3'd0;
  localparam logic [2:0] EXIT_OK = 3'd1;
  localparam logic [2:0] EXIT_CANCEL = 3'd2;
  localparam logic [2:0] EXIT_SYNC = 3'd3;
  localparam logic [2:0] EXIT_RETRY = 3'd4;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RETRANS = 2'd1;
  localparam logic [1:0] REG_SYNC = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SYNC    = 5'b00010,
    PH_CANWAIT = 5'b00100,
    PH_BODY    = 5'b01000,
    PH_FLUSH   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    INV_C    = 2'd0,
    INV_NAK  = 2'd1,
    INV_NONE = 2'd2
  } invite_t;

  typedef enum logic [1:0] {
    REP_NONE = 2'd0,
    REP_NAK  = 2'd1,
    REP_ACK  = 2'd2,
    REP_CAN3 = 2'd3
  } reply_t;

  typedef struct packed {
    logic [15:0] timeout_unit;
    logic [7:0]  retrans_limit;
    logic [7:0]  sync_tries;
  } cfg_t;

  typedef struct packed {
    logic       txv;
    logic [7:0] tx;
    logic       dv;
    logic [7:0] db;
    logic [1:0] verdict;
  } item_t;

  typedef struct packed {
    logic [1:0]        n;
    item_t [2:0]       it;
    logic [2:0]        status;
    logic [31:0]       total;
  } grp_t;

  typedef struct packed {
    phase_t          phase;
    invite_t         invite;
    logic [7:0]      try_count;
    logic [16:0]     tick_count;
    logic [7:0]      expected_seq;
    logic [7:0]      packet_seq;
    logic [7:0]      packet_seq_inv;
    logic [PosW-1:0] byte_pos;
    logic            crc_mode;
    logic            long_packet;
    logic [7:0]      run_sum;
    logic [15:0]     run_crc;
    logic [15:0]     rx_check;
    logic [7:0]      retrans_left;
    logic [31:0]     total_bytes;
    reply_t          pending;
    logic [2:0]      exit_code;
  } st_t;

  function automatic st_t session_init(logic [7:0] rl);
    st_t s;
    s = '0;
    s.phase = PH_IDLE;
    s.invite = INV_C;
    s.expected_seq = 8'd1;
    s.pending = REP_NONE;
    s.exit_code = EXIT_RUN;
    s.retrans_left = rl;
    return s;
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ 16'h1021) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  function automatic item_t mk_item(logic txv, logic [7:0] tx, logic dv, logic [7:0] db,
                                    logic [1:0] v);
    item_t r;
    r.txv = txv;
    r.tx = tx;
    r.dv = dv;
    r.db = db;
    r.verdict = v;
    return r;
  endfunction

endpackage

### src/xmr_regs.sv
// apb configuration registers: timeout unit, retransmit limit, sync tries
// depends on xmr_pkg
module xmr_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output xmr_pkg::cfg_t    cfg
);
  import xmr_pkg::*;

  logic wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_unit <= 16'd1000;
      cfg.retrans_limit <= 8'd25;
      cfg.sync_tries <= 8'd16;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[3:2] == REG_TIMEOUT) cfg.timeout_unit <= pwdata[15:0];
      if (paddr[3:2] == REG_RETRANS) cfg.retrans_limit <= pwdata[7:0];
      if (paddr[3:2] == REG_SYNC) cfg.sync_tries <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_TIMEOUT: prdata = {16'd0, cfg.timeout_unit};
      REG_RETRANS: prdata = {24'd0, cfg.retrans_limit};
      REG_SYNC:    prdata = {24'd0, cfg.sync_tries};
      default:     prdata = '0;
    endcase
  end
endmodule

### src/xmr_core.sv
// protocol state and per-item update; emits one group of up to three results
// depends on xmr_pkg
module xmr_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [1:0]      action,
  input  logic [7:0]      rx_byte,
  input  xmr_pkg::cfg_t   cfg,
  output xmr_pkg::grp_t   grp
);
  import xmr_pkg::*;

  st_t st, st_next;

  always_comb begin
    st_t         s;
    item_t [2:0] it;
    logic [1:0]  n;
    logic        ea;
    logic        fin;
    logic [1:0]  v;
    reply_t      r;
    logic [PosW-1:0] size;
    logic        inv_ok, is_new, is_dup, chk_ok;
    logic [17:0] flush_lim;
    s = st;
    it = '0;
    n = 2'd0;
    ea = 1'b0;
    fin = 1'b0;
    v = VERD_NONE;
    r = REP_NONE;
    size = st.long_packet ? PosW'(MaxPayload) : PosW'(ShortPayload);
    flush_lim = ({2'b00, cfg.timeout_unit} * 18'd3) >> 1;
    inv_ok = 1'b0;
    is_new = 1'b0;
    is_dup = 1'b0;
    chk_ok = 1'b0;
    unique case (action)
      ACT_START: begin
        v = (st.phase == PH_BODY) ? VERD_DISCARD : VERD_NONE;
        s = session_init(cfg.retrans_limit);
        s.phase = PH_SYNC;
        it[n] = mk_item(1'b1, CH_INV, 1'b0, 8'd0, v); n = n + 2'd1;
      end
      ACT_BYTE: begin
        priority case (st.phase)
          PH_SYNC: begin
            if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
              s.long_packet = (rx_byte == CH_STX);
              if (st.invite == INV_C) s.crc_mode = 1'b1;
              s.invite = INV_NONE;
              s.phase = PH_BODY;
              s.byte_pos = '0;
              s.tick_count = '0;
              s.run_sum = '0;
              s.run_crc = '0;
              s.rx_check = '0;
            end else if (rx_byte == CH_EOT) begin
              s.phase = PH_FLUSH; s.pending = REP_ACK; s.exit_code = EXIT_OK;
              s.tick_count = '0;
            end else if (rx_byte == CH_CAN) begin
              s.phase = PH_CANWAIT;
              s.tick_count = '0;
            end else begin
              ea = 1'b1;
            end
          end
          PH_CANWAIT: begin
            if (rx_byte == CH_CAN) begin
              s.phase = PH_FLUSH; s.pending = REP_ACK; s.exit_code = EXIT_CANCEL;
              s.tick_count = '0;
            end else begin
              ea = 1'b1;
            end
          end
          PH_BODY: begin
            s.tick_count = '0;
            if (st.byte_pos == '0) begin
              s.packet_seq = rx_byte;
            end else if (st.byte_pos == PosW'(1)) begin
              s.packet_seq_inv = rx_byte;
            end else if (st.byte_pos < size + PosW'(2)) begin
              s.run_sum = st.run_sum + rx_byte;
              s.run_crc = crc_byte(st.run_crc, rx_byte);
              it[n] = mk_item(1'b0, 8'd0, 1'b1, rx_byte, VERD_NONE); n = n + 2'd1;
            end else begin
              s.rx_check = {st.rx_check[7:0], rx_byte};
            end
            s.byte_pos = st.byte_pos + PosW'(1);
            fin = s.byte_pos >= size + PosW'(3) + PosW'(st.crc_mode);
          end
          PH_FLUSH: s.tick_count = '0;
          default: ;
        endcase
      end
      ACT_TICK: begin
        if (st.phase != PH_IDLE && st.tick_count < TICK_MAX)
          s.tick_count = st.tick_count + 17'd1;
        priority case (st.phase)
          PH_IDLE: ;
          PH_SYNC: ea = {1'b0, s.tick_count} >= {1'b0, cfg.timeout_unit, 1'b0};
          PH_CANWAIT: ea = s.tick_count >= {1'b0, cfg.timeout_unit};
          PH_BODY: begin
            if (s.tick_count >= {1'b0, cfg.timeout_unit}) begin
              it[n] = mk_item(1'b0, 8'd0, 1'b0, 8'd0, VERD_DISCARD); n = n + 2'd1;
              s.phase = PH_FLUSH; s.pending = REP_NAK; s.exit_code = EXIT_RUN;
              s.tick_count = '0;
            end
          end
          PH_FLUSH: begin
            if ({1'b0, s.tick_count} >= flush_lim) begin
              r = st.pending;
              s.pending = REP_NONE;
              if (r == REP_NAK) begin
                it[n] = mk_item(1'b1, CH_NAK, 1'b0, 8'd0, VERD_NONE); n = n + 2'd1;
                s.phase = PH_SYNC; s.try_count = '0; s.tick_count = '0;
                if (s.invite == INV_C) begin
                  it[n] = mk_item(1'b1, CH_INV, 1'b0, 8'd0, VERD_NONE); n = n + 2'd1;
                end else if (s.invite == INV_NAK) begin
                  it[n] = mk_item(1'b1, CH_NAK, 1'b0, 8'd0, VERD_NONE); n = n + 2'd1;
                end
              end else begin
                if (r == REP_ACK) begin
                  it[n] = mk_item(1'b1, CH_ACK, 1'b0, 8'd0, VERD_NONE); n = n + 2'd1;
                end else if (r == REP_CAN3) begin
                  it[0] = mk_item(1'b1, CH_CAN, 1'b0, 8'd0, VERD_NONE);
                  it[1] = it[0];
                  it[2] = it[0];
                  n = 2'd3;
                end
                s.phase = PH_IDLE;
              end
            end
          end
          default: s.phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase

    // packet complete: check and verdict
    if (fin) begin
      inv_ok = s.packet_seq_inv == ~s.packet_seq;
      is_new = s.packet_seq == s.expected_seq;
      is_dup = s.packet_seq == s.expected_seq - 8'd1;
      chk_ok = s.crc_mode ? (s.rx_check == s.run_crc) : (s.rx_check[7:0] == s.run_sum);
      if (inv_ok && (is_new || is_dup) && chk_ok) begin
        if (is_new) begin
          v = VERD_COMMIT;
          s.total_bytes = (32'hFFFF_FFFF - s.total_bytes < 32'(size)) ?
                          32'hFFFF_FFFF : s.total_bytes + 32'(size);
          s.expected_seq = s.expected_seq + 8'd1;
          s.retrans_left = cfg.retrans_limit;
        end else begin
          v = VERD_DISCARD;
          s.retrans_left = (s.retrans_left != 8'd0) ? s.retrans_left - 8'd1 : 8'd0;
        end
        if (s.retrans_left == 8'd0) begin
          it[n] = mk_item(1'b0, 8'd0, 1'b0, 8'd0, v); n = n + 2'd1;
          s.phase = PH_FLUSH; s.pending = REP_CAN3; s.exit_code = EXIT_RETRY;
          s.tick_count = '0;
        end else begin
          it[n] = mk_item(1'b1, CH_ACK, 1'b0, 8'd0, v); n = n + 2'd1;
          s.phase = PH_SYNC; s.try_count = '0; s.tick_count = '0;
        end
      end else begin
        it[n] = mk_item(1'b0, 8'd0, 1'b0, 8'd0, VERD_DISCARD); n = n + 2'd1;
        s.phase = PH_FLUSH; s.pending = REP_NAK; s.exit_code = EXIT_RUN;
        s.tick_count = '0;
      end
    end

    // header wait over: retry, switch invite, or give up
    if (ea) begin
      s.try_count = st.try_count + 8'd1;
      if (s.try_count < cfg.sync_tries) begin
        s.phase = PH_SYNC;
        s.tick_count = '0;
        if (s.invite == INV_C) begin
          it[n] = mk_item(1'b1, CH_INV, 1'b0, 8'd0, VERD_NONE); n = n + 2'd1;
        end else if (s.invite == INV_NAK) begin
          it[n] = mk_item(1'b1, CH_NAK, 1'b0, 8'd0, VERD_NONE); n = n + 2'd1;
        end
      end else if (s.invite == INV_C) begin
        s.invite = INV_NAK;
        s.phase = PH_SYNC; s.try_count = '0; s.tick_count = '0;
        it[n] = mk_item(1'b1, CH_NAK, 1'b0, 8'd0, VERD_NONE); n = n + 2'd1;
      end else begin
        s.phase = PH_FLUSH; s.pending = REP_CAN3; s.exit_code = EXIT_SYNC;
        s.tick_count = '0;
      end
    end

    // quiet step still yields one empty result
    if (n == 2'd0) n = 2'd1;
    st_next = s;
    grp.n = n;
    grp.it = it;
    grp.status = (s.phase == PH_IDLE) ? s.exit_code : EXIT_RUN;
    grp.total = s.total_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= session_init(8'd25);
    end else if (fire) begin
      st <= st_next;
    end
  end
endmodule

### src/xmr_outq.sv
// two-deep queue of result groups, drained one result per cycle while out_ready is high
// depends on xmr_pkg
module xmr_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  xmr_pkg::grp_t  grp,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output xmr_pkg::item_t out_item,
  output logic [2:0]     out_status,
  output logic [31:0]    out_total,
  output logic           out_last
);
  import xmr_pkg::*;

  grp_t       q0, q1;
  logic [1:0] cnt, cnt_next;
  logic [1:0] idx;
  logic       pop, pop_grp;

  assign can_push = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_item = q0.it[idx];
  assign out_status = q0.status;
  assign out_total = q0.total;
  assign out_last = idx == q0.n - 2'd1;
  assign pop = out_valid && out_ready;
  assign pop_grp = pop && out_last;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop_grp) cnt_next = cnt + 2'd1;
    else if (!push && pop_grp) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (pop_grp) idx <= 2'd0;
      else if (pop) idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_grp) begin
      if (cnt == 2'd2) q0 <= q1;
      else if (push) q0 <= grp;
      if (push && cnt == 2'd2) q1 <= grp;
    end else if (push) begin
      if (cnt == 2'd0) q0 <= grp;
      else q1 <= grp;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop_grp) |=> cnt == 2'd2)
    else $error("full queue lost a group");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (idx < q0.n))
    else $error("result index past group size");
  a_idx_clear: assert property (@(posedge clk) disable iff (rst)
    pop_grp |=> idx == 2'd0)
    else $error("result index not rewound");
endmodule

### src/xmodem_receiver.sv
// top level of the xmodem receiver: config registers, protocol core, result queue
// depends on xmr_pkg, xmr_regs, xmr_core, xmr_outq
//
//  channel   handshake          payload
//  input     valid / ready      action, rx_byte
//  output    out_valid/ready    tx_valid tx_byte data_valid data_byte verdict
//                               session_status byte_count last
//  config    apb psel/penable   paddr pwdata prdata
//
// one input item per cycle while ready is high; its state update is combinational logic in the core
// an item gives one to three results, sent one per cycle while out_ready is high, from a two-group queue
// ready drops only while two groups are waiting on the output side
// synchronous reset restores register defaults and an idle session
module xmodem_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [1:0]  verdict,
  output logic [2:0]  session_status,
  output logic [31:0] byte_count,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xmr_pkg::*;

  cfg_t  cfg;
  grp_t  grp;
  item_t item;
  logic  fire;

  assign fire = valid && ready;

  xmr_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  xmr_core u_core (
    .clk(clk), .rst(rst), .fire(fire), .action(action), .rx_byte(rx_byte),
    .cfg(cfg), .grp(grp)
  );

  xmr_outq u_outq (
    .clk(clk), .rst(rst), .push(fire), .grp(grp), .can_push(ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(item),
    .out_status(session_status), .out_total(byte_count), .out_last(last)
  );

  assign tx_valid = item.txv;
  assign tx_byte = item.tx;
  assign data_valid = item.dv;
  assign data_byte = item.db;
  assign verdict = item.verdict;
endmodule
